### src/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg: shared types of the message chunk splitter
// Command and status groups between controller and datapath, controller
// states and fixed field widths.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // fixed widths of the payload fields
  localparam int unsigned FieldBits = 40;
  localparam int unsigned IndexBits = 6;
  localparam int unsigned KibBits   = 16;
  localparam int unsigned SplitBits = 7;
  // bytes per KiB as a shift
  localparam int unsigned KibShift  = 10;
  // accumulator for count search: 64 * 65535 fits in 23 bits
  localparam int unsigned AccBits   = 23;

  // configuration register indexes
  localparam logic RegChunkSizeKib = 1'b0;
  localparam logic RegMaxSplit     = 1'b1;

  // reset values of the configuration registers
  localparam logic [KibBits-1:0]   ChunkSizeKibReset = 16'd64;
  localparam logic [SplitBits-1:0] MaxSplitReset     = 7'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic cnt_step;
    logic div_init;
    logic div_step;
    logic emit_init;
    logic emit_next;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_zero;
    logic cnt_done;
    logic div_done;
    logic last_chunk;
  } sts_t;

endpackage

### src/mcs_ctrl.sv
// ----------------------------------------------------------------------------
// mcs_ctrl: sequencer of the message chunk splitter
// Walks each message through count search, division and chunk emission.
// ----------------------------------------------------------------------------
module mcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mcs_pkg::sts_t sts_i,
  output mcs_pkg::cmd_t cmd_o
);
  import mcs_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.in_zero) begin
            state_d = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (sts_i.cnt_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIVIDE;
        end else begin
          cmd_o.cnt_step = 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.last_chunk) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/mcs_dp.sv
// ----------------------------------------------------------------------------
// mcs_dp: datapath of the message chunk splitter
// Chunk count search, bit-serial ceiling division and chunk offset walk.
// ----------------------------------------------------------------------------
module mcs_dp #(
  parameter int unsigned MAX_CHUNKS = 64,
  parameter int unsigned SIZE_BITS  = 40
) (
  input  logic                             clk_i,
  input  logic [mcs_pkg::FieldBits-1:0]    message_bytes_i,
  input  logic [mcs_pkg::KibBits-1:0]      chunk_size_kib_i,
  input  logic [mcs_pkg::SplitBits-1:0]    max_split_i,
  input  mcs_pkg::cmd_t                    cmd_i,
  output mcs_pkg::sts_t                    sts_o,
  output logic [mcs_pkg::FieldBits-1:0]    chunk_offset_o,
  output logic [mcs_pkg::FieldBits-1:0]    chunk_length_o,
  output logic [mcs_pkg::IndexBits-1:0]    chunk_index_o
);
  import mcs_pkg::*;

  // effective size width after masking to SIZE_BITS
  localparam int unsigned SW  = (SIZE_BITS < FieldBits) ? SIZE_BITS : FieldBits;
  localparam int unsigned CW  = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned DcW = $clog2(SW + 1);
  localparam int unsigned S1W = SW - KibShift + 1;

  logic [SW-1:0]      size_q;
  logic [KibBits-1:0] kib_q;
  logic [CW-1:0]      cap_q;
  logic [AccBits-1:0] acc_q;
  logic [CW-1:0]      cnt_q;
  logic [SW-1:0]      quo_q;
  logic [CW-1:0]      rem_q;
  logic [DcW-1:0]     dcnt_q;
  logic [SW-1:0]      reg_q;
  logic [SW:0]        off_q;
  logic [CW-1:0]      idx_q;

  logic [SW-1:0]      in_size;
  logic [CW-1:0]      cap_in;
  logic [S1W-1:0]     size_kib;
  logic [CW:0]        rem_sh;
  logic               rem_ge;
  logic [SW:0]        size_ext;
  logic [SW:0]        reg_ext;
  logic [SW:0]        left;
  logic [SW:0]        len;
  logic [63:0]        off_wide;
  logic [63:0]        len_wide;
  logic [63:0]        idx_wide;

  // masked input size and clamped split limit
  assign in_size = message_bytes_i[SW-1:0];
  always_comb begin
    if (max_split_i == '0) begin
      cap_in = CW'(1);
    end else if (32'(max_split_i) > MAX_CHUNKS) begin
      cap_in = CW'(MAX_CHUNKS);
    end else begin
      cap_in = CW'(max_split_i);
    end
  end

  // size in KiB rounded up, so count search compares against multiples of kib
  assign size_kib = {1'b0, size_q[SW-1:KibShift]} + S1W'(|size_q[KibShift-1:0]);

  // one restoring division step with the chunk count as divisor
  assign rem_sh = {rem_q, quo_q[SW-1]};
  assign rem_ge = rem_sh >= {1'b0, cnt_q};

  // chunk length: lesser of regular size and bytes left
  assign size_ext = {1'b0, size_q};
  assign reg_ext  = {1'b0, reg_q};
  assign left     = size_ext - off_q;
  always_comb begin
    if (off_q >= size_ext) begin
      len = '0;
    end else if (reg_ext < left) begin
      len = reg_ext;
    end else begin
      len = left;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q <= in_size;
      kib_q  <= (chunk_size_kib_i == '0) ? KibBits'(1) : chunk_size_kib_i;
      acc_q  <= (chunk_size_kib_i == '0) ? AccBits'(1) : AccBits'(chunk_size_kib_i);
      cap_q  <= cap_in;
      cnt_q  <= CW'(1);
    end
    if (cmd_i.cnt_step) begin
      acc_q <= acc_q + AccBits'(kib_q);
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.div_init) begin
      quo_q  <= size_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SW-2:0], rem_ge};
      rem_q  <= rem_ge ? CW'(rem_sh - {1'b0, cnt_q}) : CW'(rem_sh);
      dcnt_q <= dcnt_q + DcW'(1);
    end
    if (cmd_i.emit_init) begin
      // ceiling of the quotient
      reg_q <= quo_q + SW'(rem_q != '0);
      off_q <= '0;
      idx_q <= '0;
    end
    if (cmd_i.emit_next) begin
      off_q <= off_q + reg_ext;
      idx_q <= idx_q + CW'(1);
    end
  end

  // status
  assign sts_o.in_zero    = (in_size == '0);
  assign sts_o.cnt_done   = (acc_q >= size_kib) || (cnt_q == cap_q);
  assign sts_o.div_done   = (dcnt_q == DcW'(SW));
  assign sts_o.last_chunk = ((idx_q + CW'(1)) == cnt_q);

  // result fields
  assign off_wide       = 64'(off_q);
  assign len_wide       = 64'(len);
  assign idx_wide       = 64'(idx_q);
  assign chunk_offset_o = off_wide[FieldBits-1:0];
  assign chunk_length_o = len_wide[FieldBits-1:0];
  assign chunk_index_o  = idx_wide[IndexBits-1:0];

endmodule

### src/message_chunk_splitter_top.sv
// ----------------------------------------------------------------------------
// message_chunk_splitter_top: splits a message size into transfer chunks
// Configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one message size per beat.
//   The block works on one message at a time and stalls the input until the
//   last chunk of the message has been taken.
//   Per message: a load step, a count search for the chunk count n (one
//   add and compare per candidate count), bit-serial division for the
//   regular chunk size, then one chunk beat per cycle on the output channel
//   while out_stall_i is low; a zero-sized message gives no beats.
//   Output channel (out_valid_o / out_stall_i) holds offset, length, index
//   and last stable while out_stall_i is high.
//   The APB port writes chunk_size_kib at 0x0 and max_split at 0x4; write it
//   only while the block is idle.
//   Reset clears the controller to idle and sets chunk_size_kib to 64 and
//   max_split to 16.
// ----------------------------------------------------------------------------
module message_chunk_splitter_top #(
  parameter int unsigned MAX_CHUNKS = 64,
  parameter int unsigned SIZE_BITS  = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mcs_pkg::FieldBits-1:0] message_bytes_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mcs_pkg::FieldBits-1:0] chunk_offset_o,
  output logic [mcs_pkg::FieldBits-1:0] chunk_length_o,
  output logic [mcs_pkg::IndexBits-1:0] chunk_index_o,
  output logic                          last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mcs_pkg::*;

  logic [KibBits-1:0]   chunk_size_kib_q;
  logic [SplitBits-1:0] max_split_q;
  logic                 cfg_wr;
  cmd_t                 cmd;
  sts_t                 sts;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_kib_q <= ChunkSizeKibReset;
      max_split_q      <= MaxSplitReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegChunkSizeKib) begin
        chunk_size_kib_q <= pwdata[KibBits-1:0];
      end else begin
        max_split_q <= pwdata[SplitBits-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == RegMaxSplit) begin
      prdata = {{(32 - SplitBits){1'b0}}, max_split_q};
    end else begin
      prdata = {{(32 - KibBits){1'b0}}, chunk_size_kib_q};
    end
  end

  mcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcs_dp #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .message_bytes_i  (message_bytes_i),
    .chunk_size_kib_i (chunk_size_kib_q),
    .max_split_i      (max_split_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .chunk_offset_o   (chunk_offset_o),
    .chunk_length_o   (chunk_length_o),
    .chunk_index_o    (chunk_index_o)
  );

  assign last_o = sts.last_chunk;

  // no new message is taken while chunks are going out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while emitting chunks");

  // a zero-sized message never produces a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.in_zero) |=> !out_valid_o)
    else $error("zero-sized message produced a chunk");

  // the final chunk ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("chunk emitted after the final chunk");

  // chunk index steps by one within a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && chunk_index_o == $past(chunk_index_o) + IndexBits'(1)))
    else $error("chunk index did not advance by one");

  // first chunk of a run starts at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (chunk_offset_o == '0 && chunk_index_o == '0))
    else $error("run did not start at offset zero");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the message chunk splitter
// Drives message sizes with random gaps and stalls the chunk beats at random.
// Every accepted size is split by a local predictor, and each chunk beat is
// compared field by field with the oldest expected chunk. The configuration
// is rewritten between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import mcs_pkg::*;

  localparam int unsigned MaxChunks   = 64;
  localparam int unsigned SizeBits    = 40;
  localparam longint unsigned KibBytes = 1024;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned SettleCycles = 200;
  localparam longint unsigned LimitCycles = 4_000_000;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseItems  = 21;

  typedef struct packed {
    logic [FieldBits-1:0] chunk_offset;
    logic [FieldBits-1:0] chunk_length;
    logic [IndexBits-1:0] chunk_index;
    logic                 last;
  } chunk_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [FieldBits-1:0] message_bytes_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [FieldBits-1:0] chunk_offset_o;
  logic [FieldBits-1:0] chunk_length_o;
  logic [IndexBits-1:0] chunk_index_o;
  logic                 last_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // configuration shadow as the predictor sees it
  logic [KibBits-1:0]   kib_cfg = ChunkSizeKibReset;
  logic [SplitBits-1:0] split_cfg = MaxSplitReset;

  logic [FieldBits-1:0] pending_sizes[$];
  chunk_t               expected_chunks[$];
  chunk_t               want;
  bit                   quiet_phase = 1'b0;
  int unsigned          gap_left = 0;
  int unsigned          stall_left = 0;
  int unsigned          errors = 0;
  longint unsigned      cycles = 0;

  message_chunk_splitter_top #(
    .MAX_CHUNKS(MaxChunks),
    .SIZE_BITS (SizeBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_bytes_i(message_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .chunk_offset_o (chunk_offset_o),
    .chunk_length_o (chunk_length_o),
    .chunk_index_o  (chunk_index_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // nominal chunk size in bytes, a zero setting counts as one KiB
  function automatic longint unsigned nominal_bytes();
    return longint'((kib_cfg == '0) ? 1 : kib_cfg) * KibBytes;
  endfunction

  // effective split limit after the zero and saturation rules
  function automatic longint unsigned split_cap();
    longint unsigned cap;
    cap = (split_cfg == '0) ? 1 : split_cfg;
    if (cap > MaxChunks) cap = MaxChunks;
    return cap;
  endfunction

  // split one message and queue the chunks it must produce
  function automatic void split_message(input logic [FieldBits-1:0] msg_bytes);
    longint unsigned size, nominal, count, reg_sz, ofs, rem, len, i;
    chunk_t c;
    size = msg_bytes & ((64'd1 << SizeBits) - 1);
    nominal = nominal_bytes();
    if (size == 0) begin
      return;
    end
    count = (size + nominal - 1) / nominal;
    if (count > split_cap()) count = split_cap();
    reg_sz = (size + count - 1) / count;
    for (i = 0; i < count; i++) begin
      ofs = i * reg_sz;
      // a chunk starting at or past the end is empty
      rem = (ofs < size) ? size - ofs : 0;
      len = (reg_sz < rem) ? reg_sz : rem;
      c.chunk_offset = ofs[FieldBits-1:0];
      c.chunk_length = len[FieldBits-1:0];
      c.chunk_index = i[IndexBits-1:0];
      c.last = (i + 1 == count);
      expected_chunks.push_back(c);
    end
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random message size aimed at the current setting
  function automatic logic [FieldBits-1:0] pick_size();
    longint unsigned nominal, cap, raw;
    int unsigned r;
    nominal = nominal_bytes();
    cap = split_cap();
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    // spread over the uncapped range
    if (r < 45) return FieldBits'(raw % (nominal * (cap + 1)) + 1);
    // exact multiples of the nominal size and their neighbors
    if (r < 60) return FieldBits'(nominal * $urandom_range(1, cap + 1) - 1 + $urandom_range(0, 2));
    if (r < 80) return raw[FieldBits-1:0];
    return raw[FieldBits-1:0] >> $urandom_range(1, FieldBits - 1);
  endfunction

  // register write with setup and access cycles
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegChunkSizeKib) kib_cfg = value[KibBits-1:0];
    else split_cfg = value[SplitBits-1:0];
  endtask

  // wait until every size is taken and every chunk has come out
  task automatic drain();
    while (pending_sizes.size() != 0 || in_valid_i || expected_chunks.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // size driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) split_message(message_bytes_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_sizes.size() != 0) begin
          in_valid_i <= 1'b1;
          message_bytes_i <= pending_sizes.pop_front();
          gap_left <= pick_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // chunk monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chunks.size() == 0) begin
        $error("unexpected chunk beat: offset %0h length %0h index %0d",
               chunk_offset_o, chunk_length_o, chunk_index_o);
        errors++;
      end else begin
        want = expected_chunks.pop_front();
        if (chunk_offset_o !== want.chunk_offset) begin
          $error("chunk_offset: expected %0h, got %0h", want.chunk_offset, chunk_offset_o);
          errors++;
        end
        if (chunk_length_o !== want.chunk_length) begin
          $error("chunk_length: expected %0h, got %0h", want.chunk_length, chunk_length_o);
          errors++;
        end
        if (chunk_index_o !== want.chunk_index) begin
          $error("chunk_index: expected %0d, got %0d", want.chunk_index, chunk_index_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          errors++;
        end
      end
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left <= pick_idle();
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // reset, directed phases, random phases, final verdict
  initial begin
    logic [31:0] kib_val, split_val;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: boundaries of the default nominal size and cap
    pending_sizes = '{40'd0, 40'd1, 40'd1023, 40'd1024, 40'd1025, 40'd65535, 40'd65536,
                      40'd65537, 40'd1048576, 40'd1048577, 40'd0, 40'hFF_FFFF_FFFF, 40'd3};
    drain();

    // zero chunk size and zero split limit
    write_reg(RegChunkSizeKib, 32'd0);
    write_reg(RegMaxSplit, 32'd0);
    pending_sizes = '{40'd1, 40'd1024, 40'd1025, 40'hFF_FFFF_FFFF};
    drain();

    // largest chunk size, split limit beyond the chunk maximum
    write_reg(RegChunkSizeKib, 32'h0000_FFFF);
    write_reg(RegMaxSplit, 32'd127);
    pending_sizes = '{40'hFF_FFFF_FFFF, 40'd4_398_002_176, 40'd4_398_002_177, 40'd1};
    drain();

    // smallest chunk size, full cap reached exactly
    write_reg(RegChunkSizeKib, 32'd1);
    write_reg(RegMaxSplit, 32'd64);
    pending_sizes = '{40'd65536, 40'd65537};
    drain();

    // random settings with random sizes
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      case ($urandom_range(0, 5))
        0: kib_val = 32'd0;
        1: kib_val = 32'd1;
        2: kib_val = 32'h0000_FFFF;
        3, 4: kib_val = $urandom_range(1, 16);
        default: kib_val = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0: split_val = 32'd0;
        1: split_val = 32'd1;
        2: split_val = 32'd64;
        3: split_val = 32'd127;
        4: split_val = $urandom_range(65, 126);
        default: split_val = $urandom_range(1, 64);
      endcase
      // unused upper bits carry noise
      write_reg(RegChunkSizeKib, ($urandom & 32'hFFFF_0000) | kib_val);
      write_reg(RegMaxSplit, ($urandom & 32'hFFFF_FF80) | split_val);
      quiet_phase = (p % 4 == 3);
      for (int unsigned k = 0; k < PhaseItems; k++) pending_sizes.push_back(pick_size());
      drain();
    end

    if (expected_chunks.size() != 0) begin
      $error("%0d expected chunks never arrived", expected_chunks.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
